@@ rtl/spq_pkg.sv @@
package spq_pkg;

    // Command codes on the request channel
    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_PEEK    = 2'd2,
        CMD_SEARCH  = 2'd3
    } t_cmd;

    // Status codes on the response channel
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // What every cell does in a cycle
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHIFT  = 2'd2
    } t_cell_op;

    // Sequencer states, one-hot
    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_SEARCH = 2'b10
    } t_state;

endpackage

@@ rtl/spq_if.sv @@
// Request channel: command, id and severity
interface spq_cmd_if #(
    parameter int ID_BITS  = 16,
    parameter int SEV_BITS = 3
);
    logic                valid;
    logic                ready;
    logic [1:0]          command;
    logic [ID_BITS-1:0]  patient_id;
    logic [SEV_BITS-1:0] severity;

    modport source (output valid, output command, output patient_id, output severity,
                    input ready);
    modport sink   (input valid, input command, input patient_id, input severity,
                    output ready);
endinterface

// Response channel: status, returned entry and count
interface spq_rsp_if #(
    parameter int ID_BITS  = 16,
    parameter int SEV_BITS = 3,
    parameter int CNT_BITS = 5
);
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [ID_BITS-1:0]  out_id;
    logic [SEV_BITS-1:0] out_severity;
    logic [CNT_BITS-1:0] queue_count;

    modport source (output valid, output status, output out_id, output out_severity,
                    output queue_count, input ready);
    modport sink   (input valid, input status, input out_id, input out_severity,
                    input queue_count, output ready);
endinterface

@@ rtl/spq_cell.sv @@
// One slot of the sorted chain. Holds an entry and trades it with its neighbors.
module spq_cell #(
    parameter int ID_BITS  = 16,
    parameter int SEV_BITS = 3
) (
    input  logic                i_clk,
    input  spq_pkg::t_cell_op   i_op,
    input  logic                i_occupied,
    input  logic [ID_BITS-1:0]  i_new_id,
    input  logic [SEV_BITS-1:0] i_new_sev,
    input  logic                i_left_keep,
    input  logic [ID_BITS-1:0]  i_left_id,
    input  logic [SEV_BITS-1:0] i_left_sev,
    input  logic [ID_BITS-1:0]  i_right_id,
    input  logic [SEV_BITS-1:0] i_right_sev,
    output logic                o_keep,
    output logic [ID_BITS-1:0]  o_id,
    output logic [SEV_BITS-1:0] o_sev
);

    logic [ID_BITS-1:0]  r_id;
    logic [SEV_BITS-1:0] r_sev;
    logic [ID_BITS-1:0]  n_id;
    logic [SEV_BITS-1:0] n_sev;

    // Entry stays ahead of a new one of equal or lower severity
    assign o_keep = i_occupied && (r_sev >= i_new_sev);

    always_comb begin
        n_id  = r_id;
        n_sev = r_sev;
        unique case (i_op)
            spq_pkg::OP_INSERT: begin
                if (o_keep) begin
                    n_id  = r_id;
                    n_sev = r_sev;
                end else if (i_left_keep) begin
                    n_id  = i_new_id;
                    n_sev = i_new_sev;
                end else begin
                    n_id  = i_left_id;
                    n_sev = i_left_sev;
                end
            end
            spq_pkg::OP_SHIFT: begin
                n_id  = i_right_id;
                n_sev = i_right_sev;
            end
            default: begin
                n_id  = r_id;
                n_sev = r_sev;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_id  <= n_id;
        r_sev <= n_sev;
    end

    assign o_id  = r_id;
    assign o_sev = r_sev;

endmodule

@@ rtl/stable_priority_queue.sv @@
// Stable priority queue of up to DEPTH (id, severity) entries, held in a chain of
// cells sorted by severity, high first, first-in first-out among equal severities.
// On an enqueue every cell decides locally whether to keep its entry, take the new
// one or take its left neighbor's, and a dequeue shifts the chain toward the head.
// A search rotates the whole chain once past the head cell, one cell per cycle,
// takes no new request until it is done and leaves the order unchanged. A response
// waits in an output register, and the next request is taken while it is being
// transferred. Every response carries the count.
module stable_priority_queue #(
    parameter int DEPTH    = 16,
    parameter int ID_BITS  = 16,
    parameter int SEV_BITS = 3
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    spq_cmd_if.sink   i_cmd,
    spq_rsp_if.source o_rsp
);

    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int SCAN_BITS = $clog2(DEPTH);
    localparam logic [CNT_BITS-1:0]  DEPTH_CNT = CNT_BITS'(DEPTH);
    localparam logic [SCAN_BITS-1:0] LAST_SCAN = SCAN_BITS'(DEPTH - 1);

    // Control state
    spq_pkg::t_state       r_state, n_state;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [SCAN_BITS-1:0]  r_scan, n_scan;
    logic                  r_found, n_found;
    logic                  r_rsp_valid, n_rsp_valid;

    // Payload registers
    logic [ID_BITS-1:0]    r_target, n_target;
    logic [ID_BITS-1:0]    r_hit_id, n_hit_id;
    logic [SEV_BITS-1:0]   r_hit_sev, n_hit_sev;
    spq_pkg::t_status      r_status, n_status;
    logic [ID_BITS-1:0]    r_out_id, n_out_id;
    logic [SEV_BITS-1:0]   r_out_sev, n_out_sev;
    logic [CNT_BITS-1:0]   r_out_cnt, n_out_cnt;

    logic                  w_accept;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_hit;
    spq_pkg::t_cmd         w_cmd;
    spq_pkg::t_cell_op     w_op;
    logic [DEPTH-1:0]      w_keep;
    logic [ID_BITS-1:0]    w_id  [DEPTH];
    logic [SEV_BITS-1:0]   w_sev [DEPTH];

    assign i_cmd.ready = (r_state == spq_pkg::S_IDLE) && (!r_rsp_valid || o_rsp.ready);
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_cmd       = spq_pkg::t_cmd'(i_cmd.command);
    assign w_full      = (r_count == DEPTH_CNT);
    assign w_empty     = (r_count == '0);
    assign w_hit       = (CNT_BITS'(r_scan) < r_count) && (w_id[0] == r_target) && !r_found;

    // Chain operation for this cycle
    always_comb begin
        w_op = spq_pkg::OP_HOLD;
        if (r_state == spq_pkg::S_SEARCH) begin
            w_op = spq_pkg::OP_SHIFT;
        end else if (w_accept && w_cmd == spq_pkg::CMD_ENQUEUE && !w_full) begin
            w_op = spq_pkg::OP_INSERT;
        end else if (w_accept && w_cmd == spq_pkg::CMD_DEQUEUE && !w_empty) begin
            w_op = spq_pkg::OP_SHIFT;
        end
    end

    // Chain of cells; the tail takes the head's entry so a shift is a rotation
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam logic [CNT_BITS-1:0] SLOT = CNT_BITS'(g);
        localparam int LEFT  = (g == 0) ? 0 : g - 1;
        localparam int RIGHT = (g == DEPTH - 1) ? 0 : g + 1;

        spq_cell #(
            .ID_BITS  (ID_BITS),
            .SEV_BITS (SEV_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_op        (w_op),
            .i_occupied  (SLOT < r_count),
            .i_new_id    (i_cmd.patient_id),
            .i_new_sev   (i_cmd.severity),
            .i_left_keep ((g == 0) ? 1'b1 : w_keep[LEFT]),
            .i_left_id   (w_id[LEFT]),
            .i_left_sev  (w_sev[LEFT]),
            .i_right_id  (w_id[RIGHT]),
            .i_right_sev (w_sev[RIGHT]),
            .o_keep      (w_keep[g]),
            .o_id        (w_id[g]),
            .o_sev       (w_sev[g])
        );
    end

    // Sequencer, count and response
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_scan      = r_scan;
        n_found     = r_found;
        n_target    = r_target;
        n_hit_id    = r_hit_id;
        n_hit_sev   = r_hit_sev;
        n_rsp_valid = r_rsp_valid && !o_rsp.ready;
        n_status    = r_status;
        n_out_id    = r_out_id;
        n_out_sev   = r_out_sev;
        n_out_cnt   = r_out_cnt;

        unique case (r_state)
            spq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_out_id  = '0;
                    n_out_sev = '0;
                    n_status  = spq_pkg::ST_OK;
                    unique case (w_cmd)
                        spq_pkg::CMD_ENQUEUE: begin
                            if (w_full) begin
                                n_status = spq_pkg::ST_FULL;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                            n_rsp_valid = 1'b1;
                        end
                        spq_pkg::CMD_DEQUEUE,
                        spq_pkg::CMD_PEEK: begin
                            if (w_empty) begin
                                n_status = spq_pkg::ST_EMPTY;
                            end else begin
                                n_out_id  = w_id[0];
                                n_out_sev = w_sev[0];
                                if (w_cmd == spq_pkg::CMD_DEQUEUE) begin
                                    n_count = r_count - 1'b1;
                                end
                            end
                            n_rsp_valid = 1'b1;
                        end
                        spq_pkg::CMD_SEARCH: begin
                            n_target = i_cmd.patient_id;
                            n_scan   = '0;
                            n_found  = 1'b0;
                            n_state  = spq_pkg::S_SEARCH;
                        end
                        default: ;
                    endcase
                    n_out_cnt = n_count;
                end
            end
            spq_pkg::S_SEARCH: begin
                // Head cell is checked, then the chain rotates by one
                if (w_hit) begin
                    n_found   = 1'b1;
                    n_hit_id  = w_id[0];
                    n_hit_sev = w_sev[0];
                end
                n_scan = r_scan + 1'b1;
                if (r_scan == LAST_SCAN) begin
                    n_state     = spq_pkg::S_IDLE;
                    n_rsp_valid = 1'b1;
                    n_out_cnt   = r_count;
                    if (n_found) begin
                        n_status  = spq_pkg::ST_OK;
                        n_out_id  = n_hit_id;
                        n_out_sev = n_hit_sev;
                    end else begin
                        n_status  = spq_pkg::ST_NOT_FOUND;
                        n_out_id  = '0;
                        n_out_sev = '0;
                    end
                end
            end
            default: begin
                n_state = spq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spq_pkg::S_IDLE;
            r_count     <= '0;
            r_scan      <= '0;
            r_found     <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_scan      <= n_scan;
            r_found     <= n_found;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target  <= n_target;
        r_hit_id  <= n_hit_id;
        r_hit_sev <= n_hit_sev;
        r_status  <= n_status;
        r_out_id  <= n_out_id;
        r_out_sev <= n_out_sev;
        r_out_cnt <= n_out_cnt;
    end

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.out_id       = r_out_id;
    assign o_rsp.out_severity = r_out_sev;
    assign o_rsp.queue_count  = r_out_cnt;

`ifndef SYNTHESIS
    // Count never passes the capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("queue count above capacity");

    // A search never runs while a response is still pending
    a_search_no_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spq_pkg::S_SEARCH) |-> !r_rsp_valid)
        else $error("response pending during search");

    // A transfer of an enqueue into a queue with room grows the count by one
    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_cmd == spq_pkg::CMD_ENQUEUE && !w_full)
            |=> (r_count == $past(r_count) + 1'b1))
        else $error("enqueue did not grow the count");
`endif

endmodule

@@ sim/stable_priority_queue_tb.sv @@
module stable_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH    = 16;
    localparam int ID_BITS  = 16;
    localparam int SEV_BITS = 3;
    localparam int N_RANDOM = 450;
    localparam int PHASE    = 48;

    typedef struct packed {
        spq_pkg::t_cmd       cmd;
        logic [ID_BITS-1:0]  id;
        logic [SEV_BITS-1:0] sev;
    } t_req;

    typedef struct packed {
        spq_pkg::t_status    status;
        logic [ID_BITS-1:0]  id;
        logic [SEV_BITS-1:0] sev;
        logic [4:0]          count;
    } t_reply;

    // One row of the directed sequence; reps > 1 steps id and severity per repeat
    typedef struct packed {
        spq_pkg::t_cmd       cmd;
        logic [ID_BITS-1:0]  id;
        logic [SEV_BITS-1:0] sev;
        logic [4:0]          reps;
        logic                typed;
        t_reply              want;
    } t_dir_step;

    logic i_clk = 1'b0;
    logic i_rst_n;

    spq_cmd_if #(.ID_BITS(ID_BITS), .SEV_BITS(SEV_BITS)) cmd_bus ();
    spq_rsp_if #(.ID_BITS(ID_BITS), .SEV_BITS(SEV_BITS), .CNT_BITS(5)) rsp_bus ();

    stable_priority_queue #(
        .DEPTH    (DEPTH),
        .ID_BITS  (ID_BITS),
        .SEV_BITS (SEV_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the queue contents, head at slot 0
    logic [ID_BITS-1:0]  ward_id  [DEPTH];
    logic [SEV_BITS-1:0] ward_sev [DEPTH];
    int                  ward_held = 0;

    t_reply    expected_replies[$];
    t_dir_step dir_steps[$];
    int        mismatches = 0;
    int        burst_left = 0;
    logic      typed_now  = 1'b0;
    t_reply    typed_reply;

    // Apply one command to the shadow queue and return the reply it should produce
    function automatic t_reply triage(input t_req r);
        t_reply rep;
        int     pos;
        int     i;
        bit     found;
        rep.status = spq_pkg::ST_OK;
        rep.id     = '0;
        rep.sev    = '0;
        found      = 1'b0;
        case (r.cmd)
            spq_pkg::CMD_ENQUEUE: begin
                if (ward_held >= DEPTH) begin
                    rep.status = spq_pkg::ST_FULL;
                end else begin
                    // new entry goes behind everything of equal or higher severity
                    pos = 0;
                    while (pos < ward_held && ward_sev[pos] >= r.sev) pos++;
                    for (i = ward_held; i > pos; i--) begin
                        ward_id[i]  = ward_id[i-1];
                        ward_sev[i] = ward_sev[i-1];
                    end
                    ward_id[pos]  = r.id;
                    ward_sev[pos] = r.sev;
                    ward_held++;
                end
            end
            spq_pkg::CMD_DEQUEUE, spq_pkg::CMD_PEEK: begin
                if (ward_held == 0) begin
                    rep.status = spq_pkg::ST_EMPTY;
                end else begin
                    rep.id  = ward_id[0];
                    rep.sev = ward_sev[0];
                    if (r.cmd == spq_pkg::CMD_DEQUEUE) begin
                        for (i = 1; i < ward_held; i++) begin
                            ward_id[i-1]  = ward_id[i];
                            ward_sev[i-1] = ward_sev[i];
                        end
                        ward_held--;
                    end
                end
            end
            default: begin
                // first hit in queue order wins
                for (i = 0; i < ward_held; i++) begin
                    if (!found && ward_id[i] == r.id) begin
                        found   = 1'b1;
                        rep.id  = ward_id[i];
                        rep.sev = ward_sev[i];
                    end
                end
                if (!found) rep.status = spq_pkg::ST_NOT_FOUND;
            end
        endcase
        rep.count = 5'(ward_held);
        return rep;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t ns %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // Response check first, then the command accepted at this edge
    always @(posedge i_clk) begin
        t_reply want;
        t_req   taken;
        if (i_rst_n) begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (expected_replies.size() == 0) begin
                    flag_mismatch("response with nothing pending", rsp_bus.status, 0);
                end else begin
                    want = expected_replies.pop_front();
                    if (rsp_bus.status != want.status)
                        flag_mismatch("status", rsp_bus.status, want.status);
                    if (rsp_bus.out_id != want.id)
                        flag_mismatch("out_id", rsp_bus.out_id, want.id);
                    if (rsp_bus.out_severity != want.sev)
                        flag_mismatch("out_severity", rsp_bus.out_severity, want.sev);
                    if (rsp_bus.queue_count != want.count)
                        flag_mismatch("queue_count", rsp_bus.queue_count, want.count);
                end
            end
            if (cmd_bus.valid && cmd_bus.ready) begin
                taken.cmd = spq_pkg::t_cmd'(cmd_bus.command);
                taken.id  = cmd_bus.patient_id;
                taken.sev = cmd_bus.severity;
                want      = triage(taken);
                expected_replies.push_back(typed_now ? typed_reply : want);
            end
        end
    end

    // Present one command from a falling edge until a transfer takes it
    task automatic send(input t_req r, input logic typed, input t_reply want);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                cmd_bus.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        cmd_bus.valid      = 1'b1;
        cmd_bus.command    = r.cmd;
        cmd_bus.patient_id = r.id;
        cmd_bus.severity   = r.sev;
        typed_now          = typed;
        typed_reply        = want;
        do @(posedge i_clk); while (!cmd_bus.ready);
    endtask

    // Random command, biased toward filling or draining the queue
    function automatic t_req pick_item(input bit filling);
        t_req r;
        int   roll;
        roll = $urandom_range(0, 99);
        if (roll < (filling ? 55 : 20))
            r.cmd = spq_pkg::CMD_ENQUEUE;
        else if (roll < 70)
            r.cmd = spq_pkg::CMD_DEQUEUE;
        else if (roll < 80)
            r.cmd = spq_pkg::CMD_PEEK;
        else
            r.cmd = spq_pkg::CMD_SEARCH;
        if (r.cmd == spq_pkg::CMD_SEARCH && ward_held > 0 && $urandom_range(0, 1) == 1)
            r.id = ward_id[$urandom_range(0, ward_held - 1)];
        else if ($urandom_range(0, 3) == 0)
            r.id = ID_BITS'($urandom_range(0, 7));
        else
            r.id = ID_BITS'($urandom);
        r.sev = SEV_BITS'($urandom_range(0, 7));
        return r;
    endfunction

    // Receiver: ready pattern switches between four modes at random
    initial begin
        int mode;
        int left;
        int tick;
        rsp_bus.ready = 1'b0;
        left = 0;
        tick = 0;
        mode = 0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(8, 40);
            end
            left--;
            tick++;
            case (mode)
                0: rsp_bus.ready = 1'b1;
                1: rsp_bus.ready = tick[0];
                2: rsp_bus.ready = ($urandom_range(0, 2) != 0);
                default: rsp_bus.ready = ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // Stimulus and end of run
    initial begin
        t_dir_step s;
        t_req      r;
        t_reply    none;
        int        k;
        int        n;
        none = '{spq_pkg::ST_OK, 16'h0, 3'd0, 5'd0};
        i_rst_n            = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.command    = spq_pkg::CMD_ENQUEUE;
        cmd_bus.patient_id = '0;
        cmd_bus.severity   = '0;
        typed_reply        = none;

        // empty-queue replies, extremes, equal-severity order, duplicate ids, full
        dir_steps.push_back('{spq_pkg::CMD_DEQUEUE, 16'h0000, 3'd0, 5'd1, 1'b1,
                              '{spq_pkg::ST_EMPTY, 16'h0, 3'd0, 5'd0}});
        dir_steps.push_back('{spq_pkg::CMD_PEEK, 16'h0000, 3'd0, 5'd1, 1'b1,
                              '{spq_pkg::ST_EMPTY, 16'h0, 3'd0, 5'd0}});
        dir_steps.push_back('{spq_pkg::CMD_SEARCH, 16'hFFFF, 3'd7, 5'd1, 1'b1,
                              '{spq_pkg::ST_NOT_FOUND, 16'h0, 3'd0, 5'd0}});
        dir_steps.push_back('{spq_pkg::CMD_ENQUEUE, 16'hFFFF, 3'd7, 5'd1, 1'b1,
                              '{spq_pkg::ST_OK, 16'h0, 3'd0, 5'd1}});
        dir_steps.push_back('{spq_pkg::CMD_ENQUEUE, 16'h0000, 3'd0, 5'd1, 1'b1,
                              '{spq_pkg::ST_OK, 16'h0, 3'd0, 5'd2}});
        dir_steps.push_back('{spq_pkg::CMD_PEEK, 16'h0000, 3'd0, 5'd1, 1'b1,
                              '{spq_pkg::ST_OK, 16'hFFFF, 3'd7, 5'd2}});
        dir_steps.push_back('{spq_pkg::CMD_ENQUEUE, 16'h1234, 3'd3, 5'd1, 1'b0, none});
        dir_steps.push_back('{spq_pkg::CMD_ENQUEUE, 16'h5678, 3'd3, 5'd1, 1'b0, none});
        dir_steps.push_back('{spq_pkg::CMD_ENQUEUE, 16'h1234, 3'd5, 5'd1, 1'b0, none});
        dir_steps.push_back('{spq_pkg::CMD_SEARCH, 16'h1234, 3'd2, 5'd1, 1'b0, none});
        dir_steps.push_back('{spq_pkg::CMD_ENQUEUE, 16'h8001, 3'd1, 5'd11, 1'b0, none});
        dir_steps.push_back('{spq_pkg::CMD_ENQUEUE, 16'hBEEF, 3'd6, 5'd1, 1'b1,
                              '{spq_pkg::ST_FULL, 16'h0, 3'd0, 5'd16}});
        dir_steps.push_back('{spq_pkg::CMD_SEARCH, 16'h8005, 3'd0, 5'd1, 1'b0, none});
        dir_steps.push_back('{spq_pkg::CMD_DEQUEUE, 16'hFFFF, 3'd7, 5'd3, 1'b0, none});

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_steps[j]) begin
            s = dir_steps[j];
            for (k = 0; k < s.reps; k++) begin
                r.cmd = s.cmd;
                r.id  = s.id + ID_BITS'(k);
                r.sev = s.sev + SEV_BITS'(k);
                send(r, s.typed, s.want);
            end
        end

        for (n = 0; n < N_RANDOM; n++) begin
            r = pick_item(((n / PHASE) % 2) == 0);
            send(r, 1'b0, none);
        end

        @(negedge i_clk);
        cmd_bus.valid = 1'b0;
        typed_now     = 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 4) @(posedge i_clk);
        if (mismatches == 0)
            $display("stable_priority_queue: match");
        else
            $display("stable_priority_queue: mismatch");
        $finish;
    end

    // Watchdog
    initial begin
        #2ms;
        $display("stable_priority_queue: mismatch");
        $finish;
    end

endmodule

@@ stable_priority_queue.f @@
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
sim/stable_priority_queue_tb.sv
